@@ rtl/plp_pkg.sv @@
`default_nettype none

package plp_pkg;

	// Default widths of the internal value and polygon counters
	localparam int COORD_BITS_DEF      = 16;
	localparam int POLY_INDEX_BITS_DEF = 16;

	// Character codes
	localparam logic [7:0] LINE_END   = 8'd10;
	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [7:0] DIGIT_ZERO = 8'd48;
	localparam logic [7:0] DIGIT_ONE  = 8'd49;
	localparam logic [7:0] DIGIT_NINE = 8'd57;

	// Column positions within a line
	localparam logic [3:0] OPEN_COLUMN  = 4'd7;
	localparam logic [3:0] VALUE_COLUMN = 4'd9;
	localparam logic [3:0] COLUMN_LIMIT = 4'd10;

	// One point as it leaves the parser core
	typedef struct packed {
		logic [15:0] polygon_index;
		logic [15:0] x;
		logic [15:0] y;
		logic        new_polygon;
	} point_t;

endpackage

`default_nettype wire

@@ rtl/polygon_text_point_parser.sv @@
// Polygon text point parser.
// Input channel: in_valid/in_ready carries one text byte per transaction;
// byte 10 ends a line. Data rows (space in column 0, digit in column 9)
// give decimal values from column 9 on, paired as x,y into points.
// Output channel: out_valid/out_ready carries one point per transaction:
// polygon_index, x, y and new_polygon (first point of an opening row).
// A point is registered and appears on the output in the cycle after the
// byte that completes it (the terminating space or newline) is accepted.
// Throughput: one byte per cycle while no point is stalled in the output
// register. The parser state updates from each accepted byte and the point
// is caught in one output register.
// Stalls: while a point waits in the output register with out_ready low,
// in_ready is low; it rises in the cycle the point is taken, so a byte can
// be accepted in the same cycle the previous point leaves.
// Bytes that produce no point never occupy the output register.
// Reset (arst_n low, asynchronous) clears all line and polygon state and
// empties the output register; polygon numbering restarts from zero.
`default_nettype none

module polygon_text_point_parser #(
	parameter int COORD_BITS      = plp_pkg::COORD_BITS_DEF,
	parameter int POLY_INDEX_BITS = plp_pkg::POLY_INDEX_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      polygon_index,
	output logic signed [15:0] x,
	output logic signed [15:0] y,
	output logic             new_polygon
);

	logic            step;
	logic            emit;
	plp_pkg::point_t point;
	plp_pkg::point_t point_q;
	logic            out_valid_q;

	// Accept when the output register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	plp_core #(
		.COORD_BITS      (COORD_BITS),
		.POLY_INDEX_BITS (POLY_INDEX_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (text_byte),
		.point     (point),
		.emit      (emit)
	);

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= step && emit;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (step && emit) begin
			point_q <= point;
		end
	end

	assign out_valid     = out_valid_q;
	assign polygon_index = point_q.polygon_index;
	assign x             = point_q.x;
	assign y             = point_q.y;
	assign new_polygon   = point_q.new_polygon;

	// No new byte is taken while a point is stuck in the output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !step)
		else $error("byte accepted over a stalled point");

	// A produced point shows up on the output in the next cycle
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |=> out_valid_q)
		else $error("point lost");

	// Output empties after a transaction unless refilled
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !(step && emit)) |=> !out_valid_q)
		else $error("point repeated");

endmodule

`default_nettype wire

@@ rtl/plp_core.sv @@
`default_nettype none

module plp_core #(
	parameter int COORD_BITS      = plp_pkg::COORD_BITS_DEF,
	parameter int POLY_INDEX_BITS = plp_pkg::POLY_INDEX_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     text_byte,
	output plp_pkg::point_t     point,
	output logic                emit
);

	// Line and value state
	logic [3:0]                 col_q;
	logic                       lead_q;
	logic                       data_q;
	logic                       open_row_q;
	logic [COORD_BITS-1:0]      accum_q;
	logic                       digit_q;
	logic [COORD_BITS-1:0]      held_x_q;
	logic                       x_wait_q;
	logic [POLY_INDEX_BITS-1:0] cur_poly_q;
	logic                       poly_open_q;
	logic                       first_q;

	logic                       is_digit, is_space, is_nl;
	logic                       lead_nx, open_row_nx, data_now;
	logic                       start_poly, poly_open_now, first_now;
	logic                       in_vals, finish, store_x;
	logic [POLY_INDEX_BITS-1:0] poly_now;
	logic [COORD_BITS-1:0]      accum_digit;
	logic [COORD_BITS+15:0]     x_ext, y_ext;
	logic [POLY_INDEX_BITS+15:0] poly_ext;

	// Byte classification
	assign is_digit = (text_byte >= plp_pkg::DIGIT_ZERO) && (text_byte <= plp_pkg::DIGIT_NINE);
	assign is_space = (text_byte == plp_pkg::SPACE_CHAR);
	assign is_nl    = (text_byte == plp_pkg::LINE_END);

	// Row qualification for the current byte
	assign lead_nx     = (col_q == 4'd0) ? is_space : lead_q;
	assign open_row_nx = (col_q == plp_pkg::OPEN_COLUMN) ? (text_byte == plp_pkg::DIGIT_ONE)
	                                                     : open_row_q;
	assign data_now    = (col_q == plp_pkg::VALUE_COLUMN) ? (lead_q && is_digit) : data_q;
	assign start_poly  = !is_nl && (col_q == plp_pkg::VALUE_COLUMN) && data_now && open_row_q;

	// Polygon numbering
	always_comb begin
		poly_now = cur_poly_q;
		if (start_poly) begin
			poly_now = poly_open_q ? cur_poly_q + POLY_INDEX_BITS'(1) : '0;
		end
	end
	assign poly_open_now = poly_open_q || start_poly;
	assign first_now     = first_q || start_poly;

	// Value termination and pairing
	assign in_vals = !is_nl && (col_q >= plp_pkg::VALUE_COLUMN) && data_now;
	assign finish  = is_nl ? (data_q && digit_q) : (in_vals && is_space);
	assign emit    = finish && poly_open_now && x_wait_q;
	assign store_x = finish && poly_open_now && !x_wait_q;

	// accum * 10 + digit, wrapping at COORD_BITS
	assign accum_digit = (accum_q << 3) + (accum_q << 1)
	                   + {{(COORD_BITS-4){1'b0}}, text_byte[3:0]};

	// Point fields cut or extended to 16 bits
	assign x_ext    = {16'b0, held_x_q};
	assign y_ext    = {16'b0, accum_q};
	assign poly_ext = {16'b0, poly_now};
	assign point.polygon_index = poly_ext[15:0];
	assign point.x             = x_ext[15:0];
	assign point.y             = y_ext[15:0];
	assign point.new_polygon   = first_now;

	// State update on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			lead_q      <= 1'b0;
			data_q      <= 1'b0;
			open_row_q  <= 1'b0;
			accum_q     <= '0;
			digit_q     <= 1'b0;
			held_x_q    <= '0;
			x_wait_q    <= 1'b0;
			cur_poly_q  <= '0;
			poly_open_q <= 1'b0;
			first_q     <= 1'b0;
		end else if (step) begin
			if (is_nl) begin
				col_q      <= '0;
				lead_q     <= 1'b0;
				data_q     <= 1'b0;
				open_row_q <= 1'b0;
				accum_q    <= '0;
				digit_q    <= 1'b0;
				x_wait_q   <= 1'b0;
				first_q    <= 1'b0;
			end else begin
				if (col_q < plp_pkg::COLUMN_LIMIT) begin
					col_q <= col_q + 4'd1;
				end
				lead_q      <= lead_nx;
				open_row_q  <= open_row_nx;
				data_q      <= data_now;
				cur_poly_q  <= poly_now;
				poly_open_q <= poly_open_now;
				// first flag drops once the row's first point leaves
				first_q     <= first_now && !emit;
				if (in_vals && is_digit) begin
					accum_q <= accum_digit;
					digit_q <= 1'b1;
				end else if (finish) begin
					accum_q <= '0;
					digit_q <= 1'b0;
					if (emit) begin
						x_wait_q <= 1'b0;
					end else if (store_x) begin
						held_x_q <= accum_q;
						x_wait_q <= 1'b1;
					end
				end
			end
		end
	end

	// Column counter saturates at the limit
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= plp_pkg::COLUMN_LIMIT)
		else $error("column counter past limit");

	// A point needs a held x and an open polygon
	a_emit_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (x_wait_q && poly_open_now))
		else $error("point without x or polygon");

	// Newline clears the per-line state
	a_nl_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_nl) |=> (col_q == 4'd0 && !data_q && !x_wait_q && !digit_q))
		else $error("line state not cleared");

	// Once a polygon is open it stays open
	a_poly_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		poly_open_q |=> poly_open_q)
		else $error("polygon open flag dropped");

	// A held x never exists outside a polygon
	a_x_in_poly: assert property (@(posedge clk) disable iff (!arst_n)
		x_wait_q |-> poly_open_q)
		else $error("x held without polygon");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_BYTES = 1450;
	localparam int QUIET_LIMIT = 4000;
	localparam int IDLE_PCT    = 34;
	localparam int HOLD_CYCLES = 400;

	// Predicts the points of the text stream and checks the ones leaving the block
	class point_scoreboard;
		plp_pkg::point_t expected_points[$];
		int errors = 0;

		logic [3:0]  column = '0;
		logic        lead_space = 1'b0;
		logic        data_row = 1'b0;
		logic        opens_row = 1'b0;
		logic [15:0] accum = '0;
		logic        have_digit = 1'b0;
		logic [15:0] x_hold = '0;
		logic        x_held = 1'b0;
		logic [15:0] poly = '0;
		logic        poly_open = 1'b0;
		logic        first_pending = 1'b0;

		function void note_failure(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// A value ends: it becomes x, or pairs with the held x into a point
		function void close_value();
			plp_pkg::point_t p;
			logic [15:0] v;
			v = accum;
			accum = '0;
			have_digit = 1'b0;
			if (!poly_open)
				return;
			if (x_held) begin
				p.polygon_index = poly;
				p.x = x_hold;
				p.y = v;
				p.new_polygon = first_pending;
				expected_points.push_back(p);
				first_pending = 1'b0;
				x_held = 1'b0;
			end else begin
				x_hold = v;
				x_held = 1'b1;
			end
		endfunction

		// Called for every accepted byte transaction
		function void take_byte(logic [7:0] b);
			logic       is_digit;
			logic [3:0] c;
			is_digit = (b >= plp_pkg::DIGIT_ZERO) && (b <= plp_pkg::DIGIT_NINE);
			c = column;
			if (b == plp_pkg::LINE_END) begin
				if (data_row && have_digit)
					close_value();
				column = '0;
				lead_space = 1'b0;
				data_row = 1'b0;
				opens_row = 1'b0;
				accum = '0;
				have_digit = 1'b0;
				x_held = 1'b0;
				first_pending = 1'b0;
				return;
			end
			if (c == 4'd0)
				lead_space = (b == plp_pkg::SPACE_CHAR);
			if (c == plp_pkg::OPEN_COLUMN)
				opens_row = (b == plp_pkg::DIGIT_ONE);
			// row classification and polygon numbering happen at the first value column
			if (c == plp_pkg::VALUE_COLUMN) begin
				data_row = lead_space && is_digit;
				if (data_row && opens_row) begin
					poly = poly_open ? poly + 16'd1 : 16'd0;
					poly_open = 1'b1;
					first_pending = 1'b1;
				end
			end
			if (c >= plp_pkg::VALUE_COLUMN && data_row) begin
				if (is_digit) begin
					accum = accum * 16'd10 + {8'h00, b - plp_pkg::DIGIT_ZERO};
					have_digit = 1'b1;
				end else if (b == plp_pkg::SPACE_CHAR) begin
					close_value();
				end
			end
			if (c < plp_pkg::COLUMN_LIMIT)
				column = c + 4'd1;
		endfunction

		// Called for every accepted point transaction
		function void check_point(plp_pkg::point_t got);
			plp_pkg::point_t want;
			if (expected_points.size() == 0) begin
				note_failure($sformatf("unexpected point: poly %0d x %0d y %0d first %0b",
					got.polygon_index, $signed(got.x), $signed(got.y), got.new_polygon));
				return;
			end
			want = expected_points.pop_front();
			if (got.polygon_index !== want.polygon_index || got.x !== want.x ||
					got.y !== want.y || got.new_polygon !== want.new_polygon)
				note_failure($sformatf(
					"point mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
					want.polygon_index, $signed(want.x), $signed(want.y), want.new_polygon,
					got.polygon_index, $signed(got.x), $signed(got.y), got.new_polygon));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] polygon_index;
	logic signed [15:0] x;
	logic signed [15:0] y;
	logic        new_polygon;

	point_scoreboard sb = new();

	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int bytes_sent = 0;
	int quiet = 0;

	polygon_text_point_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.polygon_index (polygon_index),
		.x             (x),
		.y             (y),
		.new_polygon   (new_polygon)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, a stall-free stretch, and one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_point({polygon_index, x, y, new_polygon});
			if (in_valid && in_ready)
				sb.take_byte(text_byte);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Offers one byte, starting and ending at a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		text_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] any_but_newline();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == plp_pkg::LINE_END);
		return b;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == plp_pkg::LINE_END || b == plp_pkg::SPACE_CHAR ||
			(b >= plp_pkg::DIGIT_ZERO && b <= plp_pkg::DIGIT_NINE));
		return b;
	endfunction

	function automatic logic [7:0] rand_digit();
		return plp_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Well-formed data row with random header bytes and random fields
	task automatic send_data_row(input bit opening);
		int nvals;
		int ndig;
		logic [7:0] b;
		send_byte(plp_pkg::SPACE_CHAR);
		repeat (6) send_byte(any_but_newline());
		if (opening) begin
			send_byte(plp_pkg::DIGIT_ONE);
		end else begin
			do
				b = any_but_newline();
			while (b == plp_pkg::DIGIT_ONE);
			send_byte(b);
		end
		send_byte(any_but_newline());
		nvals = $urandom_range(1, 7);
		for (int i = 0; i < nvals; i++) begin
			// first field must start with a digit at the value column
			ndig = (i == 0) ? $urandom_range(1, 6) : $urandom_range(0, 6);
			if ($urandom_range(0, 15) == 0) begin
				send_text((i == 0 || $urandom_range(0, 1)) ? "65535" : "32768");
			end else begin
				for (int d = 0; d < ndig; d++) begin
					send_byte(rand_digit());
					if ($urandom_range(0, 24) == 0)
						send_byte(junk_char());
				end
			end
			if (i < nvals - 1 || $urandom_range(0, 3) == 0)
				send_byte(plp_pkg::SPACE_CHAR);
		end
		send_byte(plp_pkg::LINE_END);
	endtask

	// Random bytes, newline included
	task automatic send_noise_line();
		int len;
		len = $urandom_range(0, 16);
		repeat (len) send_byte(8'($urandom_range(0, 255)));
		send_byte(plp_pkg::LINE_END);
	endtask

	// Leading space but no digit at the value column
	task automatic send_near_miss_row();
		int len;
		send_byte(plp_pkg::SPACE_CHAR);
		repeat (8) send_byte(any_but_newline());
		send_byte($urandom_range(0, 1) ? plp_pkg::SPACE_CHAR : junk_char());
		len = $urandom_range(0, 10);
		repeat (len) send_byte($urandom_range(0, 1) ? rand_digit() : plp_pkg::SPACE_CHAR);
		send_byte(plp_pkg::LINE_END);
	endtask

	// Sender stops until every predicted point has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_points.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int kind;
		bit paused;
		bit held;
		paused = 1'b0;
		held = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows
		send_text(" abcde!0x5 6\n");          // continuation before any polygon
		send_text(" pppppp1q1 2 3 4\n");      // opening row, two points
		send_text(" pppppp1q7\n");            // opening row, odd value dropped
		send_text(" pppppp0q65535 99999\n");  // wrapping values
		send_text(" pppppp1q0  5 \n");        // empty field, trailing odd value
		send_text(" pppppp1q 3 4\n");         // space at value column
		send_text(" 12\n");                   // short line
		send_text("Xpppppp1q5 6\n");          // no leading space
		send_text(" pppppp0q1a2 3b4 \n");     // stray characters in values
		send_text("\n");
		send_text(" pppppp0q8 9\n");          // newline ends the y value
		send_byte(plp_pkg::SPACE_CHAR);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("abcd1e32768 32767 1 2 3 4 5 6 7\n");
		send_text(" pppppp1q5\n");            // opening row without points
		send_text(" pppppp0q4 4\n");

		// Random rows
		while (bytes_sent < TOTAL_BYTES) begin
			if (!paused && bytes_sent >= 500) begin
				paused = 1'b1;
				wait_drained();
			end
			steady = (bytes_sent >= 800 && bytes_sent < 1050);
			if (!held && bytes_sent >= 1150) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 20)
				send_data_row(1'b1);
			else if (kind < 75)
				send_data_row(1'b0);
			else if (kind < 90)
				send_noise_line();
			else
				send_near_miss_row();
		end

		wait_drained();
		if (sb.errors == 0 && sb.expected_points.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
